/* rtl/pmt_pkg.sv */
`timescale 1ns / 1ps
package pmt_pkg;
  localparam int MAX_PEERS_DEF = 8;
  localparam logic [15:0] EXPIRE_RST = 16'd6000;
  localparam logic [7:0] VERSION_RST = 8'd4;

  localparam logic [1:0] REQ_STATE = 2'd0;
  localparam logic [1:0] REQ_LEAVE = 2'd1;
  localparam logic [1:0] REQ_SWEEP = 2'd2;

  localparam logic [2:0] ST_FOREIGN = 3'd0;
  localparam logic [2:0] ST_ECHO    = 3'd1;
  localparam logic [2:0] ST_LEFT    = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_LIFE    = 3'd4;
  localparam logic [2:0] ST_UPDATED = 3'd5;
  localparam logic [2:0] ST_ADOPTED = 3'd6;
  localparam logic [2:0] ST_SWEPT   = 3'd7;

  localparam logic [2:0] CFG_PIN = 3'd0;
  localparam logic [2:0] CFG_SELF = 3'd1;
  localparam logic [2:0] CFG_LINK = 3'd2;
  localparam logic [2:0] CFG_VER = 3'd3;
  localparam logic [2:0] CFG_EXP = 3'd4;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] now_ms;
    logic [15:0] pkt_pin;
    logic [47:0] sender_address;
    logic [7:0]  pkt_version;
    logic [31:0] pkt_turn;
    logic [31:0] pkt_epoch;
    logic [39:0] pkt_round_bytes;
  } req_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;     // capture request, clear scan results
    logic scan;     // examine slot at scan index
    logic apply;    // perform table update
    logic rank;     // rank/count pass over slot at scan index
    logic finish;   // build the result
  } cmd_t;

  typedef struct packed {
    logic last_slot;
  } sts_t;
endpackage

/* rtl/peer_member_table_with_aging.sv */
`timescale 1ns / 1ps
// Peer member table with aging.
// Slave stream s_axis_* carries one request per beat: a state packet, a
// leave packet or an expiry sweep. Master stream m_axis_* returns exactly one
// result beat per request, in order.
// Configuration writes arrive on cfg_valid/cfg_ready with a register index
// (0 group pin, 1 own address, 2 link enable, 3 expected version, 4 expiry)
// and are accepted in every cycle; write them only while the block is idle.
// Each request is carried from acceptance to result valid in steps: one pass
// over the slots for lookup, free-slot search and expiry, an update step, a
// second pass for counting and ranking, and a result step. The next request is
// taken after the result beat leaves.
// Reset clears the table and round state and restores register defaults.
// While the receiver stalls, the result holds and no new request is taken.
module peer_member_table_with_aging #(
  parameter int MAX_PEERS = pmt_pkg::MAX_PEERS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // from bit 0: now_ms[31:0], pkt_pin[47:32], sender_address[95:48],
  // pkt_version[103:96], pkt_life[119:104], pkt_alive[120], pkt_turn[152:121],
  // pkt_epoch[184:153], pkt_round_bytes[224:185], zero fill to 232
  input  logic [231:0] s_axis_tdata,
  // from bit 0: req_type[1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // from bit 0: member_count[3:0], self_seat[7:4], sender_seat[11:8],
  // dropped_any[12], new_round[13], round_lead_pos[21:14],
  // round_players[29:22], round_turn[61:30], round_epoch[93:62],
  // round_holders[109:94], zero fill to 112
  output logic [111:0] m_axis_tdata,
  // from bit 0: status[2:0]
  output logic [2:0]   m_axis_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [47:0]  cfg_data
);
  import pmt_pkg::*;

  cmd_t cmd;
  sts_t sts;
  req_t rq;

  assign rq.req_type = s_axis_tuser;
  assign rq.now_ms = s_axis_tdata[31:0];
  assign rq.pkt_pin = s_axis_tdata[47:32];
  assign rq.sender_address = s_axis_tdata[95:48];
  assign rq.pkt_version = s_axis_tdata[103:96];
  assign rq.pkt_turn = s_axis_tdata[152:121];
  assign rq.pkt_epoch = s_axis_tdata[184:153];
  assign rq.pkt_round_bytes = s_axis_tdata[224:185];

  assign cfg_ready = 1'b1;
  assign m_axis_tdata[111:110] = 2'b00;

  pmt_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .cmd(cmd), .sts(sts)
  );

  pmt_datapath #(.MAX_PEERS(MAX_PEERS)) u_dp (
    .clk(clk), .rst(rst), .in_req(rq), .cmd(cmd), .sts(sts),
    .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .status(m_axis_tuser),
    .member_count(m_axis_tdata[3:0]),
    .self_seat(m_axis_tdata[7:4]),
    .sender_seat(m_axis_tdata[11:8]),
    .dropped_any(m_axis_tdata[12]),
    .new_round(m_axis_tdata[13]),
    .round_lead_pos(m_axis_tdata[21:14]),
    .round_players(m_axis_tdata[29:22]),
    .round_turn(m_axis_tdata[61:30]),
    .round_epoch(m_axis_tdata[93:62]),
    .round_holders(m_axis_tdata[109:94])
  );
endmodule

/* rtl/pmt_ctrl.sv */
`timescale 1ns / 1ps
module pmt_ctrl (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  logic         out_ready,
  output pmt_pkg::cmd_t cmd,
  input  pmt_pkg::sts_t sts
);
  import pmt_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_APPLY = 6'b000100,
    S_RANK  = 6'b001000,
    S_DONE  = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t state, state_next;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: if (in_valid) begin
        cmd.load = 1'b1;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.last_slot) state_next = S_APPLY;
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        state_next = S_RANK;
      end
      S_RANK: begin
        cmd.rank = 1'b1;
        if (sts.last_slot) state_next = S_DONE;
      end
      S_DONE: begin
        cmd.finish = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end
endmodule

/* rtl/pmt_datapath.sv */
`timescale 1ns / 1ps
module pmt_datapath #(
  parameter int MAX_PEERS = pmt_pkg::MAX_PEERS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  pmt_pkg::req_t in_req,
  input  pmt_pkg::cmd_t cmd,
  output pmt_pkg::sts_t sts,
  input  logic          cfg_valid,
  input  logic [2:0]    cfg_index,
  input  logic [47:0]   cfg_data,
  output logic [2:0]    status,
  output logic [3:0]    member_count,
  output logic [3:0]    self_seat,
  output logic [3:0]    sender_seat,
  output logic          dropped_any,
  output logic          new_round,
  output logic [7:0]    round_lead_pos,
  output logic [7:0]    round_players,
  output logic [31:0]   round_turn,
  output logic [31:0]   round_epoch,
  output logic [15:0]   round_holders
);
  import pmt_pkg::*;

  localparam int IW = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
  localparam int CW = $clog2(MAX_PEERS + 2);

  logic [15:0] group_pin;
  logic [47:0] self_address;
  logic        link_enable;
  logic [7:0]  expected_version;
  logic [15:0] age_limit;

  logic [MAX_PEERS-1:0] slot_used;
  logic [47:0] slot_address [MAX_PEERS];
  logic [31:0] slot_last_seen [MAX_PEERS];

  logic [31:0] local_epoch, shared_turn;
  logic [7:0]  shared_lead_pos, shared_players, shared_gen, shared_monarch;
  logic [7:0]  shared_initiative;

  req_t        rq;
  logic [IW-1:0] idx;
  logic        hit, free_found, dropped, fresh;
  logic [IW-1:0] hit_idx, free_idx, k;
  logic [CW-1:0] members, below, rnk;
  logic [2:0]  st;

  logic [47:0] a_i;
  logic [31:0] silence;
  logic        lastslot;

  assign a_i = slot_address[idx];
  assign silence = rq.now_ms - slot_last_seen[idx];
  assign lastslot = (idx == IW'(MAX_PEERS - 1));
  assign sts.last_slot = lastslot;

  function automatic logic [3:0] sat15(input logic [CW-1:0] v);
    return (32'(v) > 15) ? 4'd15 : 4'(v);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      group_pin <= '0;
      self_address <= '0;
      link_enable <= 1'b0;
      expected_version <= VERSION_RST;
      age_limit <= EXPIRE_RST;
      slot_used <= '0;
      local_epoch <= '0;
      shared_lead_pos <= '0;
      shared_players <= 8'd2;
      shared_turn <= 32'd1;
      shared_gen <= '0;
      shared_monarch <= '0;
      shared_initiative <= '0;
      for (int i = 0; i < MAX_PEERS; i++) begin
        slot_address[i] <= '0;
        slot_last_seen[i] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_PIN:  group_pin <= cfg_data[15:0];
          CFG_SELF: self_address <= cfg_data;
          CFG_LINK: link_enable <= cfg_data[0];
          CFG_VER:  expected_version <= cfg_data[7:0];
          CFG_EXP:  age_limit <= cfg_data[15:0];
          default: ;
        endcase
      end

      if (cmd.load) begin
        rq <= in_req;
        idx <= '0;
        hit <= 1'b0;
        free_found <= 1'b0;
        dropped <= 1'b0;
        fresh <= 1'b0;
        hit_idx <= '0;
        free_idx <= '0;
      end

      if (cmd.scan) begin
        idx <= lastslot ? '0 : idx + 1'b1;
        if (rq.req_type == REQ_SWEEP) begin
          if (slot_used[idx] && slot_last_seen[idx] != 0 &&
              silence > {16'd0, age_limit}) begin
            slot_used[idx] <= 1'b0;
            dropped <= 1'b1;
          end
        end else begin
          if (slot_used[idx] && a_i == rq.sender_address && !hit) begin
            hit <= 1'b1;
            hit_idx <= idx;
          end
          if (!slot_used[idx] && !free_found) begin
            free_found <= 1'b1;
            free_idx <= idx;
          end
        end
      end

      if (cmd.apply) begin
        members <= CW'(1);
        below <= '0;
        rnk <= '0;
        k <= hit ? hit_idx : free_idx;
        st <= ST_FOREIGN;
        if (rq.req_type == REQ_SWEEP) st <= ST_SWEPT;
        else if (rq.req_type == REQ_STATE || rq.req_type == REQ_LEAVE) begin
          if (!link_enable || rq.pkt_pin != group_pin) st <= ST_FOREIGN;
          else if (rq.sender_address == self_address) st <= ST_ECHO;
          else if (rq.req_type == REQ_LEAVE) begin
            st <= ST_LEFT;
            if (hit) slot_used[hit_idx] <= 1'b0;
          end else if (!hit && !free_found) st <= ST_FULL;
          else begin
            if (!hit) begin
              slot_used[free_idx] <= 1'b1;
              slot_address[free_idx] <= rq.sender_address;
            end
            slot_last_seen[hit ? hit_idx : free_idx] <= rq.now_ms;
            if (rq.pkt_version != expected_version) st <= ST_LIFE;
            else if (rq.pkt_epoch > local_epoch) begin
              st <= ST_ADOPTED;
              local_epoch <= rq.pkt_epoch;
              shared_lead_pos <= rq.pkt_round_bytes[39:32];
              if (rq.pkt_round_bytes[31:24] != 0)
                shared_players <= rq.pkt_round_bytes[31:24];
              if (rq.pkt_round_bytes[23:16] != shared_gen) begin
                shared_gen <= rq.pkt_round_bytes[23:16];
                fresh <= 1'b1;
              end
              shared_turn <= rq.pkt_turn;
              shared_monarch <= rq.pkt_round_bytes[15:8];
              shared_initiative <= rq.pkt_round_bytes[7:0];
            end else st <= ST_UPDATED;
          end
        end
      end

      if (cmd.rank) begin
        idx <= lastslot ? '0 : idx + 1'b1;
        if (slot_used[idx]) begin
          members <= members + 1'b1;
          if (a_i < self_address) below <= below + 1'b1;
          if (idx != k && a_i < slot_address[k]) rnk <= rnk + 1'b1;
        end
      end

      if (cmd.finish) begin
        status <= st;
        member_count <= link_enable ? sat15(members) : 4'd1;
        self_seat <= link_enable ? sat15(below) : 4'd0;
        sender_seat <= (st == ST_LIFE || st == ST_UPDATED || st == ST_ADOPTED) ?
                       sat15(rnk + CW'(self_address < slot_address[k])) : 4'd0;
        dropped_any <= (st == ST_SWEPT) && dropped;
        new_round <= fresh;
        round_lead_pos <= shared_lead_pos;
        round_players <= shared_players;
        round_turn <= shared_turn;
        round_epoch <= local_epoch;
        round_holders <= {shared_monarch, shared_initiative};
      end
    end
  end
endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
module testbench;
  import pmt_pkg::*;

  localparam int SLOTS = 8;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  member_count;
    logic [3:0]  self_seat;
    logic [3:0]  sender_seat;
    logic        dropped_any;
    logic        new_round;
    logic [7:0]  lead_pos;
    logic [7:0]  players;
    logic [31:0] turn;
    logic [31:0] epoch;
    logic [15:0] holders;
  } member_result_t;

  class member_board;
    logic [15:0] group_pin;
    logic [47:0] self_address;
    logic        link_enable;
    logic [7:0]  expected_version;
    logic [15:0] age_limit;
    logic        used [SLOTS];
    logic [47:0] addr_of [SLOTS];
    logic [31:0] seen_at [SLOTS];
    logic [31:0] local_epoch;
    logic [7:0]  lead_pos, players, gen, monarch, initiative;
    logic [31:0] turn;
    member_result_t pending[$];
    int mismatches;
    int results_seen;
    int status_hits [8];

    function new();
      group_pin = 0; self_address = 0; link_enable = 0;
      expected_version = VERSION_RST; age_limit = EXPIRE_RST;
      for (int i = 0; i < SLOTS; i++) begin
        used[i] = 0; addr_of[i] = 0; seen_at[i] = 0;
      end
      local_epoch = 0; lead_pos = 0; players = 2; turn = 1;
      gen = 0; monarch = 0; initiative = 0;
      mismatches = 0; results_seen = 0;
      foreach (status_hits[i]) status_hits[i] = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [47:0] val);
      case (idx)
        CFG_PIN:  group_pin = val[15:0];
        CFG_SELF: self_address = val;
        CFG_LINK: link_enable = val[0];
        CFG_VER:  expected_version = val[7:0];
        CFG_EXP:  age_limit = val[15:0];
        default: ;
      endcase
    endfunction

    function logic [3:0] sat15(int v);
      return (v > 15) ? 4'd15 : v[3:0];
    endfunction

    function int slot_lookup(logic [47:0] a);
      for (int i = 0; i < SLOTS; i++)
        if (used[i] && addr_of[i] == a) return i;
      return -1;
    endfunction

    function void note_request(logic [1:0] req, logic [31:0] now, logic [15:0] pin,
                               logic [47:0] a, logic [7:0] ver, logic [31:0] t,
                               logic [31:0] ep, logic [39:0] rb);
      member_result_t r;
      int k, members, below, rank;
      r = '0;
      members = 1; below = 0;
      if (req == REQ_SWEEP) begin
        r.status = ST_SWEPT;
        for (int i = 0; i < SLOTS; i++) begin
          if (used[i] && seen_at[i] != 0 && (now - seen_at[i]) > {16'd0, age_limit}) begin
            used[i] = 0;
            r.dropped_any = 1;
          end
        end
      end else if (req == REQ_STATE || req == REQ_LEAVE) begin
        if (!link_enable || pin != group_pin) begin
          r.status = ST_FOREIGN;
        end else if (a == self_address) begin
          r.status = ST_ECHO;
        end else if (req == REQ_LEAVE) begin
          k = slot_lookup(a);
          if (k >= 0) used[k] = 0;
          r.status = ST_LEFT;
        end else begin
          k = slot_lookup(a);
          if (k < 0) begin
            for (int i = 0; i < SLOTS; i++) begin
              if (k < 0 && !used[i]) begin
                k = i; used[i] = 1; addr_of[i] = a;
              end
            end
          end
          if (k < 0) begin
            r.status = ST_FULL;
          end else begin
            seen_at[k] = now;
            rank = (self_address < addr_of[k]) ? 1 : 0;
            for (int i = 0; i < SLOTS; i++)
              if (used[i] && i != k && addr_of[i] < addr_of[k]) rank++;
            r.sender_seat = sat15(rank);
            if (ver != expected_version) begin
              r.status = ST_LIFE;
            end else if (ep > local_epoch) begin
              local_epoch = ep;
              lead_pos = rb[39:32];
              if (rb[31:24] != 0) players = rb[31:24];
              if (rb[23:16] != gen) begin
                gen = rb[23:16];
                r.new_round = 1;
              end
              turn = t;
              monarch = rb[15:8];
              initiative = rb[7:0];
              r.status = ST_ADOPTED;
            end else begin
              r.status = ST_UPDATED;
            end
          end
        end
      end else begin
        r.status = ST_FOREIGN;
      end
      if (link_enable) begin
        for (int i = 0; i < SLOTS; i++) begin
          if (used[i]) begin
            members++;
            if (addr_of[i] < self_address) below++;
          end
        end
      end
      r.member_count = sat15(members);
      r.self_seat = sat15(below);
      r.lead_pos = lead_pos;
      r.players = players;
      r.turn = turn;
      r.epoch = local_epoch;
      r.holders = {monarch, initiative};
      pending.push_back(r);
      status_hits[r.status]++;
    endfunction

    function void check_result(logic [2:0] st, logic [111:0] d);
      member_result_t want, got;
      got.status = st;
      got.member_count = d[3:0];
      got.self_seat = d[7:4];
      got.sender_seat = d[11:8];
      got.dropped_any = d[12];
      got.new_round = d[13];
      got.lead_pos = d[21:14];
      got.players = d[29:22];
      got.turn = d[61:30];
      got.epoch = d[93:62];
      got.holders = d[109:94];
      results_seen++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: %p", got);
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status || got.member_count !== want.member_count ||
          got.self_seat !== want.self_seat || got.sender_seat !== want.sender_seat ||
          got.dropped_any !== want.dropped_any || got.new_round !== want.new_round ||
          got.lead_pos !== want.lead_pos || got.players !== want.players ||
          got.turn !== want.turn || got.epoch !== want.epoch ||
          got.holders !== want.holders || d[111:110] !== 2'b00) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result %0d mismatch", results_seen);
          $display("  expected %p", want);
          $display("  actual   %p", got);
        end
      end
    endfunction
  endclass

  logic clk, rst;
  logic s_axis_tvalid, s_axis_tready;
  logic [231:0] s_axis_tdata;
  logic [1:0] s_axis_tuser;
  logic m_axis_tvalid, m_axis_tready;
  logic [111:0] m_axis_tdata;
  logic [2:0] m_axis_tuser;
  logic cfg_valid, cfg_ready;
  logic [2:0] cfg_index;
  logic [47:0] cfg_data;

  peer_member_table_with_aging u_top (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  member_board board;
  int cycles;
  bit no_idle;
  logic [31:0] clock_ms;
  logic [47:0] peers [12];
  int sent;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("testbench: FAIL");
      $finish;
    end
  end

  task automatic cfg_write(logic [2:0] idx, logic [47:0] val);
    @(negedge clk);
    cfg_valid = 1; cfg_index = idx; cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(idx, val);
    @(negedge clk);
    cfg_valid = 0;
  endtask

  task automatic send_req(logic [1:0] req, logic [31:0] now, logic [15:0] pin,
                          logic [47:0] a, logic [7:0] ver, logic [31:0] t,
                          logic [31:0] ep, logic [39:0] rb);
    int gap;
    logic [15:0] life;
    logic alive;
    gap = no_idle ? 0 : $urandom_range(0, 12);
    life = 16'($urandom);
    alive = 1'($urandom);
    repeat (gap) begin
      @(negedge clk);
      s_axis_tvalid = 0;
    end
    @(negedge clk);
    s_axis_tvalid = 1;
    s_axis_tuser = req;
    s_axis_tdata = {7'd0, rb, ep, t, alive, life, ver, a, pin, now};
    do @(posedge clk); while (!s_axis_tready);
    board.note_request(req, now, pin, a, ver, t, ep, rb);
    sent++;
  endtask

  // Drain all results, then allow a full request latency before a register write.
  task automatic settle();
    @(negedge clk);
    s_axis_tvalid = 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (2 * SLOTS + 8) @(posedge clk);
  endtask

  task automatic state_pkt(logic [47:0] a, logic [31:0] ep, logic [39:0] rb);
    send_req(REQ_STATE, clock_ms, board.group_pin, a, board.expected_version,
             $urandom, ep, rb);
  endtask

  task automatic random_item();
    int pick;
    logic [1:0] req;
    logic [15:0] pin;
    logic [47:0] a;
    logic [7:0] ver;
    logic [31:0] ep;
    logic [39:0] rb;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 19) == 0) clock_ms = $urandom;
    else clock_ms = clock_ms + $urandom_range(0, 2500);
    if (pick < 65) req = REQ_STATE;
    else if (pick < 78) req = REQ_LEAVE;
    else if (pick < 96) req = REQ_SWEEP;
    else req = 2'd3;
    pin = ($urandom_range(0, 9) == 0) ? 16'($urandom) : board.group_pin;
    pick = $urandom_range(0, 19);
    if (pick == 0) a = board.self_address;
    else if (pick == 1) a = 48'({$urandom, $urandom});
    else a = peers[$urandom_range(0, 11)];
    ver = ($urandom_range(0, 3) == 0) ? 8'($urandom) : board.expected_version;
    ep = ($urandom_range(0, 2) == 0) ? $urandom : board.local_epoch + $urandom_range(0, 3);
    rb = 40'({$urandom, $urandom});
    if ($urandom_range(0, 4) == 0) rb[31:24] = 0;
    if ($urandom_range(0, 1) == 0) rb[23:16] = board.gen;
    send_req(req, clock_ms, pin, a, ver, $urandom, ep, rb);
  endtask

  // Result side: random stalls, with bursts of no stalling.
  initial begin
    int gap;
    m_axis_tready = 0;
    @(negedge rst);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 12);
      repeat (gap) begin
        @(negedge clk);
        m_axis_tready = 0;
      end
      @(negedge clk);
      m_axis_tready = 1;
      do @(posedge clk); while (!m_axis_tvalid);
      board.check_result(m_axis_tuser, m_axis_tdata);
    end
  end

  initial begin
    logic [47:0] selves [4];
    logic [15:0] expiries [4];
    logic [7:0] versions [4];
    logic [15:0] pins [4];
    board = new();
    cycles = 0; no_idle = 0; sent = 0; clock_ms = 1000;
    rst = 1;
    s_axis_tvalid = 0; s_axis_tdata = '0; s_axis_tuser = '0;
    cfg_valid = 0; cfg_index = '0; cfg_data = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed: link down first, so packets are foreign and sweeps still run.
    state_pkt(48'h1, 1, '0);
    send_req(REQ_SWEEP, 32'd1, 0, 0, 0, 0, 0, 0);
    settle();
    cfg_write(CFG_PIN, 48'hFFFF);
    cfg_write(CFG_SELF, 48'h8000_0000_0000);
    cfg_write(CFG_LINK, 48'd1);
    cfg_write(CFG_VER, 48'd4);
    cfg_write(CFG_EXP, 48'd1);
    send_req(REQ_STATE, 32'd0, 16'hFFFF, 48'h0000_0000_0000, 8'd4, 32'hFFFF_FFFF,
             32'hFFFF_FFFF, 40'hFF_00_FF_FF_FF);
    send_req(REQ_STATE, 32'hFFFF_FFFF, 16'hFFFF, 48'hFFFF_FFFF_FFFF, 8'd4, 0, 5,
             40'h01_03_00_02_01);
    send_req(REQ_STATE, 32'd10, 16'h0000, 48'h1234, 8'd4, 0, 0, 0);
    send_req(REQ_STATE, 32'd10, 16'hFFFF, 48'h8000_0000_0000, 8'd4, 0, 0, 0);
    send_req(REQ_LEAVE, 32'd11, 16'hFFFF, 48'h5555, 8'd4, 0, 0, 0);
    send_req(2'd3, 32'd12, 16'hFFFF, 48'h1, 8'hFF, 0, 0, 0);
    for (int i = 0; i < 9; i++)
      send_req(REQ_STATE, 32'd20 + i, 16'hFFFF, 48'h100 + i * 48'h1_0000_0000,
               8'd3, 0, 0, 0);
    // Wrapped silence of two ms expires the slot stamped at the top of time.
    send_req(REQ_SWEEP, 32'd1, 16'h0, 48'h0, 8'd0, 0, 0, 0);
    send_req(REQ_LEAVE, 32'd30, 16'hFFFF, 48'h100, 8'd4, 0, 0, 0);
    send_req(REQ_SWEEP, 32'd5000, 16'h0, 48'h0, 8'd0, 0, 0, 0);
    settle();
    cfg_write(CFG_EXP, 48'd0);
    send_req(REQ_STATE, 32'd100, 16'hFFFF, 48'h42, 8'd4, 1, 0, 40'hAA_00_11_22_33);
    send_req(REQ_SWEEP, 32'd101, 0, 0, 0, 0, 0, 0);
    settle();

    selves = '{48'h0, 48'hFFFF_FFFF_FFFF, 48'h7FFF_0000_0000, 48'({$urandom, $urandom})};
    expiries = '{16'd3000, 16'd65535, 16'd1, 16'($urandom_range(500, 8000))};
    versions = '{8'd4, 8'd255, 8'd0, 8'($urandom)};
    pins = '{16'd0, 16'hFFFF, 16'($urandom), 16'($urandom)};
    for (int p = 0; p < 4; p++) begin
      cfg_write(CFG_SELF, selves[p]);
      cfg_write(CFG_EXP, expiries[p]);
      cfg_write(CFG_VER, versions[p]);
      cfg_write(CFG_PIN, pins[p]);
      cfg_write(CFG_LINK, 48'd1);
      for (int i = 0; i < 12; i++)
        peers[i] = (i < 4) ? 48'({$urandom, $urandom}) : 48'(selves[p] + i - 7);
      for (int i = 0; i < 95; i++) begin
        if (i % 30 == 0) no_idle = ($urandom_range(0, 1) == 1);
        random_item();
      end
      no_idle = 0;
      settle();
      cfg_write(CFG_LINK, 48'd0);
      for (int i = 0; i < 5; i++) random_item();
      settle();
    end

    repeat (2000) begin
      @(posedge clk);
      if (board.pending.size() == 0) break;
    end
    repeat (40) @(posedge clk);
    $display("%0d requests sent, %0d results checked over four register settings",
             sent, board.results_seen);
    $display("status counts: foreign %0d echo %0d left %0d full %0d",
             board.status_hits[0], board.status_hits[1], board.status_hits[2],
             board.status_hits[3]);
    $display("  life %0d upd %0d adopt %0d sweep %0d",
             board.status_hits[4], board.status_hits[5],
             board.status_hits[6], board.status_hits[7]);
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("%0d mismatches, %0d results missing", board.mismatches,
               board.pending.size());
      $display("testbench: FAIL");
    end
    $finish;
  end
endmodule
